[rtl/sqe_pkg.sv]
// ----------------------------------------------------------------------------
// sqe_pkg
// Shared constants, types and value helpers for the stack/queue engine.
// ----------------------------------------------------------------------------
package sqe_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int PTR_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_DUMP = 3'd1,
		OP_PEEK = 3'd2,
		OP_POP  = 3'd3,
		OP_SWAP = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_PEEK_EMPTY = 3'd1,
		ST_POP_EMPTY  = 3'd2,
		ST_SWAP_FEW   = 3'd3,
		ST_FULL       = 3'd4,
		ST_DUMP_EMPTY = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_PEEK,
		S_SWA,
		S_SWB,
		S_SWC,
		S_DOUT
	} state_t;

	typedef enum logic [1:0] {
		WR_PUSH,
		WR_A,
		WR_B
	} wr_sel_t;

	typedef enum logic [1:0] {
		RD_FRONT,
		RD_SECOND,
		RD_NEXT
	} rd_sel_t;

	typedef logic [VALUE_WIDTH-1:0] word_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    tmp_load;
		logic    push_commit;
		logic    pop_commit;
		logic    idx_clr;
		logic    idx_inc;
		logic    emit;
		logic    emit_mem;
		status_t emit_status;
		logic    emit_last;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] op;
		logic       empty;
		logic       full;
		logic       few;
		logic       dump_last;
		logic       out_free;
	} stat_t;

	function automatic word_t to_store(logic signed [31:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		return w[VALUE_WIDTH-1:0];
	endfunction

	function automatic logic signed [31:0] from_store(word_t x);
		logic signed [VALUE_WIDTH-1:0] s;
		logic signed [63:0]            w;
		s = signed'(x);
		w = 64'(s);
		return w[31:0];
	endfunction

endpackage

[rtl/sqe_if.sv]
// ----------------------------------------------------------------------------
// sqe_in_if / sqe_out_if
// Valid/ready channels for requests and results of the stack/queue engine.
// ----------------------------------------------------------------------------
interface sqe_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic signed [31:0] push_value;

	modport source (output valid, output mode, output push_value, input ready);
	modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface sqe_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_value;
	logic [2:0]         status;
	logic               last;

	modport source (output valid, output out_value, output status, output last, input ready);
	modport sink   (input valid, input out_value, input status, input last, output ready);
endinterface

[rtl/sqe_ram.sv]
// ----------------------------------------------------------------------------
// sqe_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sqe_ram #(
	parameter int W = 32,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [$clog2(D)-1:0] wr_addr,
	input  logic [W-1:0]         wr_data,
	input  logic                 rd_en,
	input  logic [$clog2(D)-1:0] rd_addr,
	output logic [W-1:0]         rd_data
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/sqe_ctrl.sv]
// ----------------------------------------------------------------------------
// sqe_ctrl
// Controller state machine: sequences each request over the datapath.
// ----------------------------------------------------------------------------
module sqe_ctrl import sqe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		in_ready        = 1'b0;
		cmd             = '0;
		cmd.wr_sel      = WR_PUSH;
		cmd.rd_sel      = RD_FRONT;
		cmd.emit_status = ST_OK;
		cmd.emit_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (st.op)
					OP_PUSH: begin
						if (st.out_free) begin
							cmd.emit = 1'b1;
							if (st.full) begin
								cmd.emit_status = ST_FULL;
							end else begin
								cmd.wr_en       = 1'b1;
								cmd.wr_sel      = WR_PUSH;
								cmd.push_commit = 1'b1;
							end
							state_d = S_IDLE;
						end
					end
					OP_POP: begin
						if (st.out_free) begin
							cmd.emit = 1'b1;
							if (st.empty) begin
								cmd.emit_status = ST_POP_EMPTY;
							end else begin
								cmd.pop_commit = 1'b1;
							end
							state_d = S_IDLE;
						end
					end
					OP_PEEK: begin
						if (st.empty) begin
							if (st.out_free) begin
								cmd.emit        = 1'b1;
								cmd.emit_status = ST_PEEK_EMPTY;
								state_d         = S_IDLE;
							end
						end else begin
							cmd.rd_en = 1'b1;
							state_d   = S_PEEK;
						end
					end
					OP_SWAP: begin
						if (st.few) begin
							if (st.out_free) begin
								cmd.emit        = 1'b1;
								cmd.emit_status = ST_SWAP_FEW;
								state_d         = S_IDLE;
							end
						end else begin
							cmd.rd_en = 1'b1;
							state_d   = S_SWA;
						end
					end
					OP_DUMP: begin
						if (st.empty) begin
							if (st.out_free) begin
								cmd.emit        = 1'b1;
								cmd.emit_status = ST_DUMP_EMPTY;
								state_d         = S_IDLE;
							end
						end else begin
							cmd.idx_clr = 1'b1;
							cmd.rd_en   = 1'b1;
							state_d     = S_DOUT;
						end
					end
					// unused codes give no result
					default: state_d = S_IDLE;
				endcase
			end
			S_PEEK: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_mem = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_SWA: begin
				cmd.tmp_load = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = RD_SECOND;
				state_d      = S_SWB;
			end
			S_SWB: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_A;
				state_d    = S_SWC;
			end
			S_SWC: begin
				if (st.out_free) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_B;
					cmd.emit   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_DOUT: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_mem  = 1'b1;
					cmd.emit_last = st.dump_last;
					if (st.dump_last) begin
						state_d = S_IDLE;
					end else begin
						// fetch the next element while this one goes out
						cmd.idx_inc = 1'b1;
						cmd.rd_en   = 1'b1;
						cmd.rd_sel  = RD_NEXT;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[rtl/sqe_dp.sv]
// ----------------------------------------------------------------------------
// sqe_dp
// Datapath: ring pointers, element store, swap holding register, result register.
// ----------------------------------------------------------------------------
module sqe_dp import sqe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic         cfg_wr_data,
	sqe_in_if.sink       in_ch,
	sqe_out_if.source    out_ch,
	input  cmd_t         cmd,
	output stat_t        st
);

	logic               mode_q;
	logic [PTR_W-1:0]   front_q;
	logic [CNT_W-1:0]   count_q;
	logic [PTR_W-1:0]   idx_q;
	logic [2:0]         op_q;
	logic signed [31:0] val_q;
	word_t              tmp_q;
	logic               out_valid_q;
	logic signed [31:0] out_value_q;
	status_t            out_status_q;
	logic               out_last_q;

	logic [PTR_W-1:0]   front_m1, second, back, next_addr;
	logic [PTR_W-1:0]   wr_addr, rd_addr;
	word_t              wr_data, rd_data;
	logic               out_free;

	function automatic logic [PTR_W-1:0] ring_add(logic [PTR_W-1:0] a, logic [PTR_W-1:0] b);
		logic [PTR_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (PTR_W+1)'(CAPACITY)) begin
			s = s - (PTR_W+1)'(CAPACITY);
		end
		return s[PTR_W-1:0];
	endfunction

	assign front_m1  = (front_q == '0) ? PTR_W'(CAPACITY - 1) : front_q - 1'b1;
	assign second    = ring_add(front_q, PTR_W'(1));
	assign back      = ring_add(front_q, count_q[PTR_W-1:0]);
	assign next_addr = ring_add(front_q, idx_q + 1'b1);

	always_comb begin
		case (cmd.wr_sel)
			WR_A: begin
				wr_addr = front_q;
				wr_data = rd_data;
			end
			WR_B: begin
				wr_addr = second;
				wr_data = tmp_q;
			end
			default: begin
				wr_addr = mode_q ? back : front_m1;
				wr_data = to_store(val_q);
			end
		endcase
		case (cmd.rd_sel)
			RD_SECOND: rd_addr = second;
			RD_NEXT:   rd_addr = next_addr;
			default:   rd_addr = front_q;
		endcase
	end

	sqe_ram #(
		.W (VALUE_WIDTH),
		.D (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			front_q <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			if (cmd.push_commit) begin
				if (!mode_q) begin
					front_q <= front_m1;
				end
				count_q <= count_q + 1'b1;
			end else if (cmd.pop_commit) begin
				front_q <= second;
				count_q <= count_q - 1'b1;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_ch.mode;
			val_q <= in_ch.push_value;
		end
		if (cmd.tmp_load) begin
			tmp_q <= rd_data;
		end
	end

	// result register: a finished result waits here for the sink
	assign out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_value_q  <= cmd.emit_mem ? from_store(rd_data) : 32'sd0;
			out_status_q <= cmd.emit_status;
			out_last_q   <= cmd.emit_last;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_value = out_value_q;
	assign out_ch.status    = out_status_q;
	assign out_ch.last      = out_last_q;

	assign st.op        = op_q;
	assign st.empty     = (count_q == '0);
	assign st.full      = (count_q == CNT_W'(CAPACITY));
	assign st.few       = (count_q < CNT_W'(2));
	assign st.dump_last = ((CNT_W'(idx_q) + 1'b1) == count_q);
	assign st.out_free  = out_free;

endmodule

[rtl/stack_queue_engine_top.sv]
// ----------------------------------------------------------------------------
// stack_queue_engine_top
// Bounded ring store of signed values, used as a stack or as a queue.
//
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        mode[2:0], push_value[31:0]
//  out_ch    out  valid/ready        out_value[31:0], status[2:0], last
//  cfg       in   cfg_wr_en          cfg_wr_data (queue_mode)
//
// one request at a time; dump reads the stored elements out one after another
// (one memory read port)
// in_ch.ready is high only while no request is in progress
// a stalled result register holds the sequencer in place until taken
// reset empties the store and selects stack mode
// ----------------------------------------------------------------------------
module stack_queue_engine_top import sqe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	sqe_in_if.sink    in_ch,
	sqe_out_if.source out_ch
);

	cmd_t  cmd;
	stat_t st;

	sqe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	sqe_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cmd         (cmd),
		.st          (st)
	);

endmodule

[rtl/sqe_chk.sv]
// ----------------------------------------------------------------------------
// sqe_chk
// Port-level checks for the stack/queue engine, bound to the top level.
// ----------------------------------------------------------------------------
module sqe_chk import sqe_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_value,
	input logic [2:0]  out_status,
	input logic        out_last
);

	// a result stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_value) && $stable(out_status)
			&& $stable(out_last))
		else $error("result changed while stalled");

	// one request at a time: busy right after a request is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// error codes always close their request with a zero value
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ST_OK |-> out_last && out_value == 32'd0)
		else $error("error result not final or not zero");

endmodule

bind stack_queue_engine_top sqe_chk u_sqe_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_value  (out_ch.out_value),
	.out_status (out_ch.status),
	.out_last   (out_ch.last)
);
